### sv/potst_pkg.sv
`default_nettype none
package potst_pkg;

  localparam int unsigned SLOTS = 16;
  localparam int unsigned IdxW  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CntW  = $clog2(SLOTS + 1);

  localparam logic [1:0] MODE_ALLOC = 2'd0;
  localparam logic [1:0] MODE_GET   = 2'd1;
  localparam logic [1:0] MODE_SET   = 2'd2;
  localparam logic [1:0] MODE_FREE  = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_UNREG = 2'd2;

  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] owner_id;
    logic [31:0] write_value;
  } in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] read_value;
  } out_t;

  typedef struct packed {
    logic            we;
    logic [IdxW-1:0] waddr;
    logic [31:0]     wdata;
    logic [IdxW-1:0] raddr;
  } ram_req_t;

endpackage
`default_nettype wire

### sv/per_owner_slot_table_unit.sv
// Per-owner slot table: a fully associative table of owner ids, each with
// one 32-bit data word.
//
// Input channel (in_valid_i / in_stall_o / in_word_i): one word is a request
// with mode (allocate, get, set, free), owner id and write value. A word is
// taken on a clock edge with valid high and stall low. Output channel
// (out_valid_o / out_stall_i / out_word_o): exactly one status word per
// request, in request order.
//
// Each request scans the owner RAM one slot per cycle through a single
// comparator; a hit ends the scan early. The input stalls for the whole
// request and reopens in the cycle after the result leaves the controller,
// so a new word is taken only once the last request is through.
// A result waits in an output register, so a stalled receiver does not
// block the next request from being taken; a second result holds in the
// controller until the register drains.
//
// Reset clears all valid bits and the output register's valid bit at once; no clearing
// pass is needed, since allocate zeroes the data word of the slot it claims.
`default_nettype none
module per_owner_slot_table_unit (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_stall_o,
  input  wire potst_pkg::in_t in_word_i,
  output logic                out_valid_o,
  input  wire logic           out_stall_i,
  output potst_pkg::out_t     out_word_o
);
  import potst_pkg::*;

  ram_req_t    own_req;
  ram_req_t    val_req;
  logic [31:0] own_rdata;
  logic [31:0] val_rdata;
  logic        busy;
  logic        res_valid;
  out_t        res;
  logic        res_take;
  logic        out_valid_q;
  out_t        out_q;

  // owner ids, read during the scan
  potst_ram #(
    .Width(32),
    .Depth(SLOTS)
  ) u_owner_ram (
    .clk_i  (clk_i),
    .we_i   (own_req.we),
    .waddr_i(own_req.waddr),
    .wdata_i(own_req.wdata),
    .raddr_i(own_req.raddr),
    .rdata_o(own_rdata)
  );

  // data words, read once for a get
  potst_ram #(
    .Width(32),
    .Depth(SLOTS)
  ) u_value_ram (
    .clk_i  (clk_i),
    .we_i   (val_req.we),
    .waddr_i(val_req.waddr),
    .wdata_i(val_req.wdata),
    .raddr_i(val_req.raddr),
    .rdata_o(val_rdata)
  );

  potst_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_valid_i(in_valid_i),
    .req_i      (in_word_i),
    .busy_o     (busy),
    .res_valid_o(res_valid),
    .res_o      (res),
    .res_take_i (res_take),
    .own_req_o  (own_req),
    .own_rdata_i(own_rdata),
    .val_req_o  (val_req),
    .val_rdata_i(val_rdata)
  );

  assign in_stall_o = busy;

  // load the output register when empty or draining this cycle
  assign res_take = res_valid && (!out_valid_q || !out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_take) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_take) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  // a taken request keeps the input stalled on the next cycle
  a_stall_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input not stalled after a request was taken");

  // a result only exists while a request is in flight
  a_result_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |-> in_stall_o)
    else $error("result offered with no request in flight");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_word_o.status == ST_OK || out_word_o.status == ST_FULL ||
                     out_word_o.status == ST_UNREG))
    else $error("undefined status code");

  a_zero_on_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_word_o.status != ST_OK)) |-> (out_word_o.read_value == 32'd0))
    else $error("read value not zero on a failed request");

endmodule
`default_nettype wire

### sv/potst_ram.sv
`default_nettype none
module potst_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16
) (
  input  wire logic                                     clk_i,
  input  wire logic                                     we_i,
  input  wire logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  wire logic [Width-1:0]                         wdata_i,
  input  wire logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic      [Width-1:0]                         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

### sv/potst_ctrl.sv
`default_nettype none
module potst_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              req_valid_i,
  input  wire potst_pkg::in_t    req_i,
  output logic                   busy_o,
  output logic                   res_valid_o,
  output potst_pkg::out_t        res_o,
  input  wire logic              res_take_i,
  output potst_pkg::ram_req_t    own_req_o,
  input  wire logic [31:0]       own_rdata_i,
  output potst_pkg::ram_req_t    val_req_o,
  input  wire logic [31:0]       val_rdata_i
);
  import potst_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_EXEC = 3'd2;
  localparam logic [2:0] S_GETW = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0]       state_q, state_d;
  logic [CntW-1:0]  iss_q, iss_d;
  logic             pend_q, pend_d;
  logic [IdxW-1:0]  cmp_idx_q, cmp_idx_d;
  logic             hit_q, hit_d;
  logic [IdxW-1:0]  hit_idx_q, hit_idx_d;
  logic             free_q, free_d;
  logic [IdxW-1:0]  free_idx_q, free_idx_d;
  logic [SLOTS-1:0] valid_q, valid_d;
  in_t              req_q, req_d;
  logic [1:0]       status_q, status_d;
  logic [31:0]      rv_q, rv_d;
  logic             issue;

  always_comb begin
    state_d    = state_q;
    iss_d      = iss_q;
    pend_d     = pend_q;
    cmp_idx_d  = cmp_idx_q;
    hit_d      = hit_q;
    hit_idx_d  = hit_idx_q;
    free_d     = free_q;
    free_idx_d = free_idx_q;
    valid_d    = valid_q;
    req_d      = req_q;
    status_d   = status_q;
    rv_d       = rv_q;
    issue      = 1'b0;

    own_req_o       = '0;
    own_req_o.raddr = iss_q[IdxW-1:0];
    val_req_o       = '0;
    val_req_o.raddr = hit_idx_q;

    case (state_q)
      S_IDLE: begin
        if (req_valid_i) begin
          req_d   = req_i;
          iss_d   = '0;
          pend_d  = 1'b0;
          hit_d   = 1'b0;
          free_d  = 1'b0;
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        // issue one owner read per cycle, compare the one returned from last cycle
        issue     = (iss_q != CntW'(SLOTS));
        pend_d    = issue;
        cmp_idx_d = iss_q[IdxW-1:0];
        if (issue) begin
          iss_d = iss_q + CntW'(1);
        end
        if (pend_q) begin
          if (!valid_q[cmp_idx_q] && !free_q) begin
            free_d     = 1'b1;
            free_idx_d = cmp_idx_q;
          end
          if (valid_q[cmp_idx_q] && (own_rdata_i == req_q.owner_id)) begin
            hit_d     = 1'b1;
            hit_idx_d = cmp_idx_q;
            state_d   = S_EXEC;
          end else if (!issue) begin
            state_d = S_EXEC;
          end
        end
      end
      S_EXEC: begin
        status_d = ST_OK;
        rv_d     = '0;
        state_d  = S_DONE;
        case (req_q.mode)
          MODE_ALLOC: begin
            if (!hit_q) begin
              if (free_q) begin
                // claim the slot and zero its data word
                valid_d[free_idx_q] = 1'b1;
                own_req_o.we        = 1'b1;
                own_req_o.waddr     = free_idx_q;
                own_req_o.wdata     = req_q.owner_id;
                val_req_o.we        = 1'b1;
                val_req_o.waddr     = free_idx_q;
                val_req_o.wdata     = '0;
              end else begin
                status_d = ST_FULL;
              end
            end
          end
          MODE_GET: begin
            if (hit_q) begin
              state_d = S_GETW;
            end else begin
              status_d = ST_UNREG;
            end
          end
          MODE_SET: begin
            if (hit_q) begin
              val_req_o.we    = 1'b1;
              val_req_o.waddr = hit_idx_q;
              val_req_o.wdata = req_q.write_value;
            end else begin
              status_d = ST_UNREG;
            end
          end
          MODE_FREE: begin
            if (hit_q) begin
              valid_d[hit_idx_q] = 1'b0;
            end
          end
          default: begin
            state_d = S_DONE;
          end
        endcase
      end
      S_GETW: begin
        rv_d    = val_rdata_i;
        state_d = S_DONE;
      end
      S_DONE: begin
        if (res_take_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      iss_q   <= '0;
      pend_q  <= 1'b0;
      hit_q   <= 1'b0;
      free_q  <= 1'b0;
      valid_q <= '0;
    end else begin
      state_q <= state_d;
      iss_q   <= iss_d;
      pend_q  <= pend_d;
      hit_q   <= hit_d;
      free_q  <= free_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmp_idx_q  <= cmp_idx_d;
    hit_idx_q  <= hit_idx_d;
    free_idx_q <= free_idx_d;
    req_q      <= req_d;
    status_q   <= status_d;
    rv_q       <= rv_d;
  end

  assign busy_o           = (state_q != S_IDLE);
  assign res_valid_o      = (state_q == S_DONE);
  assign res_o.status     = status_q;
  assign res_o.read_value = rv_q;

endmodule
`default_nettype wire

### test/tb.sv
`timescale 1ns / 100ps
module tb;
  import potst_pkg::*;

  localparam int unsigned ItemTarget  = 1600;
  localparam int unsigned PhaseLen    = 200;
  localparam int unsigned PoolSize    = 24;
  localparam int unsigned DrainCycles = 40;
  localparam int unsigned DrainLimit  = 20000;

  // One row of the directed table. A row with rep > 1 repeats with owner,
  // owner + 1, ... so the table can be filled without a row per slot.
  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] owner;
    logic [31:0] wval;
    logic [4:0]  rep;
    logic        known;
    logic [1:0]  status;
    logic [31:0] rdata;
  } probe_t;

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_stall_o;
  in_t  in_word_i;
  logic out_valid_o;
  logic out_stall_i;
  out_t out_word_o;

  per_owner_slot_table_unit u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

  // Mirror of the slot table, updated as each request word is taken.
  bit          mirror_used [SLOTS];
  logic [31:0] mirror_id   [SLOTS];
  logic [31:0] mirror_data [SLOTS];

  // Replies owed by the block, oldest first.
  out_t        awaited_replies [$];
  out_t        want_rsp;

  int unsigned words_checked;
  int unsigned mismatches;
  int unsigned full_seen;
  int unsigned unreg_seen;
  int unsigned hits_seen;

  // While steady is set neither side idles.
  bit          steady;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Hard stop in case the block hangs.
  initial begin
    #5_000_000;
    $display("timeout at %0t, %0d replies outstanding", $time, awaited_replies.size());
    $display("end of test: mismatches");
    $finish;
  end

  // Apply one request to the mirror and return the reply it owes.
  function automatic out_t apply_request(input in_t req);
    out_t rsp;
    int   hit;
    int   spare;
    rsp   = '0;
    hit   = -1;
    spare = -1;
    // Scan downward so the lowest matching and lowest free slot win.
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (mirror_used[i] && mirror_id[i] == req.owner_id) hit = i;
      if (!mirror_used[i]) spare = i;
    end
    case (req.mode)
      MODE_ALLOC: begin
        if (hit < 0) begin
          if (spare < 0) begin
            rsp.status = ST_FULL;
          end else begin
            mirror_used[spare] = 1'b1;
            mirror_id[spare]   = req.owner_id;
          end
        end
      end
      MODE_GET: begin
        if (hit < 0) rsp.status = ST_UNREG;
        else rsp.read_value = mirror_data[hit];
      end
      MODE_SET: begin
        if (hit < 0) rsp.status = ST_UNREG;
        else mirror_data[hit] = req.write_value;
      end
      default: begin
        // Free: drop the owner's slot, ignore an absent owner.
        if (hit >= 0) begin
          mirror_used[hit] = 1'b0;
          mirror_data[hit] = '0;
        end
      end
    endcase
    return rsp;
  endfunction

  // Pick a mode; while filling, allocate dominates, otherwise free does.
  function automatic logic [1:0] pick_mode(input bit filling);
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < (filling ? 40 : 15)) return MODE_ALLOC;
    if (roll < (filling ? 60 : 35)) return MODE_GET;
    if (roll < (filling ? 85 : 60)) return MODE_SET;
    return MODE_FREE;
  endfunction

  // Offer one request word, hold it until taken, then record the reply owed.
  // A typed reply from the directed table overrides the mirror's answer,
  // but the mirror still advances.
  task automatic send_word(input in_t req, input bit typed, input out_t typed_rsp);
    out_t rsp;
    while (!steady && $urandom_range(99) < 7) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i  <= req;
    // Values read right after the edge are the ones the block saw.
    do @(posedge clk_i); while (in_stall_o);
    rsp = apply_request(req);
    if (typed) rsp = typed_rsp;
    if (rsp.status == ST_FULL) full_seen++;
    if (rsp.status == ST_UNREG) unreg_seen++;
    if (req.mode == MODE_GET && rsp.status == ST_OK) hits_seen++;
    awaited_replies.push_back(rsp);
  endtask

  // Lower valid and hold off until every owed reply has come back.
  task automatic pause_until_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (awaited_replies.size() != 0) @(posedge clk_i);
  endtask

  // Receiver side: stall now and then, never during the steady stretch.
  always @(posedge clk_i) begin
    out_stall_i <= !steady && ($urandom_range(99) < 7);
  end

  // Check every reply word taken against the oldest one owed.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (awaited_replies.size() == 0) begin
        $display("%0t: unexpected reply word status=%0d read_value=%h",
                 $time, out_word_o.status, out_word_o.read_value);
        mismatches++;
      end else begin
        want_rsp = awaited_replies.pop_front();
        words_checked++;
        if (out_word_o.status !== want_rsp.status) begin
          $display("%0t: status expected %0d got %0d",
                   $time, want_rsp.status, out_word_o.status);
          mismatches++;
        end
        if (out_word_o.read_value !== want_rsp.read_value) begin
          $display("%0t: read_value expected %h got %h",
                   $time, want_rsp.read_value, out_word_o.read_value);
          mismatches++;
        end
      end
    end
  end

  initial begin : stimulus
    probe_t      probes [$];
    probe_t      row;
    in_t         req;
    out_t        rsp;
    logic [31:0] pool [PoolSize];
    int unsigned sent;
    int unsigned guard;

    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    in_word_i     = '0;
    steady        = 1'b0;
    words_checked = 0;
    mismatches    = 0;
    full_seen     = 0;
    unreg_seen    = 0;
    hits_seen     = 0;
    for (int i = 0; i < SLOTS; i++) begin
      mirror_used[i] = 1'b0;
      mirror_id[i]   = '0;
      mirror_data[i] = '0;
    end

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table: empty table, all-ones owner and data, fill to full,
    // allocate while full, reuse of a freed slot, access after free.
    probes.push_back(probe_t'{MODE_GET,   32'h0, 32'h0, 5'd1, 1'b1, ST_UNREG, 32'h0});
    probes.push_back(probe_t'{MODE_SET,   32'h0, '1,    5'd1, 1'b1, ST_UNREG, 32'h0});
    probes.push_back(probe_t'{MODE_FREE,  32'h0, 32'h0, 5'd1, 1'b1, ST_OK,    32'h0});
    probes.push_back(probe_t'{MODE_ALLOC, '1,    '1,    5'd1, 1'b1, ST_OK,    32'h0});
    probes.push_back(probe_t'{MODE_ALLOC, '1,    32'h0, 5'd1, 1'b1, ST_OK,    32'h0});
    probes.push_back(probe_t'{MODE_GET,   '1,    '1,    5'd1, 1'b1, ST_OK,    32'h0});
    probes.push_back(probe_t'{MODE_SET,   '1,    '1,    5'd1, 1'b1, ST_OK,    32'h0});
    probes.push_back(probe_t'{MODE_GET,   '1,    32'h0, 5'd1, 1'b1, ST_OK,    '1});
    probes.push_back(probe_t'{MODE_SET,   '1,    32'h0, 5'd1, 1'b1, ST_OK,    32'h0});
    probes.push_back(probe_t'{MODE_GET,   '1,    '1,    5'd1, 1'b1, ST_OK,    32'h0});
    probes.push_back(probe_t'{MODE_FREE,  '1,    32'h0, 5'd1, 1'b1, ST_OK,    32'h0});
    probes.push_back(probe_t'{MODE_GET,   '1,    32'h0, 5'd1, 1'b1, ST_UNREG, 32'h0});
    probes.push_back(probe_t'{MODE_ALLOC, 32'h1000_0000, 32'h0, 5'd16, 1'b1, ST_OK, 32'h0});
    probes.push_back(probe_t'{MODE_ALLOC, 32'h2000_0000, 32'h0, 5'd1, 1'b1, ST_FULL, 32'h0});
    probes.push_back(probe_t'{MODE_ALLOC, 32'h1000_0005, 32'h0, 5'd1, 1'b1, ST_OK, 32'h0});
    probes.push_back(probe_t'{MODE_SET, 32'h1000_0003, 32'hA5A5_A5A5, 5'd1, 1'b0, ST_OK, 32'h0});
    probes.push_back(probe_t'{MODE_GET, 32'h1000_0003, 32'h0, 5'd1, 1'b0, ST_OK, 32'h0});
    probes.push_back(probe_t'{MODE_FREE, 32'h1000_0002, 32'h0, 5'd1, 1'b0, ST_OK, 32'h0});
    probes.push_back(probe_t'{MODE_ALLOC, 32'h2000_0000, 32'h0, 5'd1, 1'b0, ST_OK, 32'h0});
    probes.push_back(probe_t'{MODE_GET, 32'h2000_0000, 32'h0, 5'd1, 1'b1, ST_OK, 32'h0});
    probes.push_back(probe_t'{MODE_SET, 32'h1000_0002, 32'h5A5A_5A5A, 5'd1, 1'b1, ST_UNREG,
                              32'h0});
    probes.push_back(probe_t'{MODE_FREE, 32'h2000_0000, 32'h0, 5'd1, 1'b0, ST_OK, 32'h0});

    // Walk the table; each row may repeat with consecutive owners.
    foreach (probes[r]) begin
      row = probes[r];
      for (int k = 0; k < row.rep; k++) begin
        req.mode        = row.mode;
        req.owner_id    = row.owner + k;
        req.write_value = row.wval;
        rsp.status      = row.status;
        rsp.read_value  = row.rdata;
        send_word(req, row.known, rsp);
      end
    end
    pause_until_drained();

    // Random part: a pool larger than the table keeps owners recurring and
    // lets the table fill; the extreme ids sit in the pool.
    pool[0] = '0;
    pool[1] = '1;
    for (int i = 2; i < PoolSize; i++) pool[i] = $urandom;

    sent = 0;
    while (sent < ItemTarget) begin
      // Hold a quiet stretch with no idling on either side.
      steady = (sent >= 600 && sent < 1000);
      if ($urandom_range(99) < 8) begin
        // Noise: any mode, any owner.
        req.mode     = 2'($urandom_range(3));
        req.owner_id = $urandom;
      end else begin
        // Alternate phases that fill the table and ones that drain it.
        req.mode     = pick_mode(((sent / PhaseLen) % 2) == 0);
        req.owner_id = pool[$urandom_range(PoolSize - 1)];
      end
      req.write_value = $urandom;
      rsp             = '0;
      send_word(req, 1'b0, rsp);
      sent++;
      if (sent % PhaseLen == 0) pause_until_drained();
    end
    steady = 1'b0;
    in_valid_i <= 1'b0;

    // Drain: wait for every owed reply, then a little longer for strays.
    guard = 0;
    while (awaited_replies.size() != 0 && guard < DrainLimit) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (DrainCycles) @(posedge clk_i);
    while (awaited_replies.size() != 0) begin
      rsp = awaited_replies.pop_front();
      $display("%0t: reply never came, expected status=%0d read_value=%h",
               $time, rsp.status, rsp.read_value);
      mismatches++;
    end

    $display("checked %0d reply words: %0d table full, %0d not registered, %0d get hits",
             words_checked, full_seen, unreg_seen, hits_seen);
    $display("directed edge cases, then %0d random requests over fill and drain phases",
             ItemTarget);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

### filelist.f
sv/potst_pkg.sv
sv/potst_ram.sv
sv/potst_ctrl.sv
sv/per_owner_slot_table_unit.sv
test/tb.sv
